### design/spwt_pkg.sv
// shared types, constants and codes for the serial pattern wait block
`timescale 1ns / 1ps
`default_nettype none

package spwt_pkg;

    // longest pattern the window can hold, one cell per byte
    localparam int PATTERN_MAX = 8;
    localparam int PAT_IDX_W   = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    // field and register widths
    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 4;
    localparam int LIMIT_W   = 8;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

    // outcome codes
    localparam logic OUT_FOUND   = 1'b0;
    localparam logic OUT_TIMEOUT = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 2'd2;

    // reset values of the registers
    localparam logic [LEN_W-1:0]   LENGTH_RESET = 4'd1;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 8'd3;

    // bytes below this value clear the window
    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h10;

    // control shared by every window cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

`default_nettype wire

### design/spwt_cell.sv
// one window cell: holds one recent byte and compares the incoming byte with its pattern byte
`timescale 1ns / 1ps
`default_nettype none

module spwt_cell (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire spwt_pkg::cell_ctl_t           ctl,
    input  wire logic                          in_use,
    input  wire logic [spwt_pkg::BYTE_W-1:0]   want,
    input  wire logic [spwt_pkg::BYTE_W-1:0]   data_in,
    input  wire logic                          valid_in,
    output logic      [spwt_pkg::BYTE_W-1:0]   data_q,
    output logic                               valid_q,
    output logic                               hit
);

    logic [spwt_pkg::BYTE_W-1:0] data_reg;
    logic [spwt_pkg::BYTE_W-1:0] data_next;
    logic                        valid_reg;
    logic                        valid_next;

    // clear wins over shift
    always_comb begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
        end else if (ctl.shift) begin
            data_next  = data_in;
            valid_next = valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // compare on the byte that moves in this cycle; unused cells always agree
    assign hit     = !in_use || (valid_in && (data_in == want));
    assign data_q  = data_reg;
    assign valid_q = valid_reg;

endmodule

`default_nettype wire

### design/serial_pattern_wait_with_idle_timeout.sv
// top level: session control, idle timer and the row of window cells
// Takes one item per clock whenever the result register is free or being drained; a byte
// or tick item that ends the session puts its result on m_valid in the next cycle. The
// compare across the row of window cells, one cell per pattern byte, is combinational and
// its hits are combined in the same cycle as the shift. Items that arrive with no open
// session give no result. Configuration writes take effect at once; the user must keep
// them to idle periods, as the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module serial_pattern_wait_with_idle_timeout (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [spwt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [spwt_pkg::CFG_W-1:0]       cfg_data,
    // item input
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [spwt_pkg::CMD_W-1:0]       s_cmd,
    input  wire logic [spwt_pkg::BYTE_W-1:0]      s_rx_byte,
    // result output
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_outcome
);

    localparam int NC = spwt_pkg::PATTERN_MAX;

    // configuration registers
    logic [spwt_pkg::CFG_W-1:0]   pattern_reg;
    logic [spwt_pkg::LEN_W-1:0]   length_reg;
    logic [spwt_pkg::LIMIT_W-1:0] limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg <= '0;
            length_reg  <= spwt_pkg::LENGTH_RESET;
            limit_reg   <= spwt_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                spwt_pkg::REG_PATTERN: pattern_reg <= cfg_data;
                spwt_pkg::REG_LENGTH:  length_reg  <= cfg_data[spwt_pkg::LEN_W-1:0];
                spwt_pkg::REG_LIMIT:   limit_reg   <= cfg_data[spwt_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective pattern length, clamped to 1..PATTERN_MAX
    logic [spwt_pkg::LEN_W-1:0] eff_len;

    always_comb begin
        if (length_reg == '0) begin
            eff_len = spwt_pkg::LEN_W'(1);
        end else if (length_reg > spwt_pkg::LEN_W'(NC)) begin
            eff_len = spwt_pkg::LEN_W'(NC);
        end else begin
            eff_len = length_reg;
        end
    end

    // pattern bytes per cell: newest byte meets the last pattern character
    logic [spwt_pkg::BYTE_W-1:0] pat_byte [NC];
    logic [spwt_pkg::BYTE_W-1:0] want     [NC];
    logic [NC-1:0]               in_use;
    logic [spwt_pkg::LEN_W-1:0]  pos      [NC];

    always_comb begin
        for (int k = 0; k < NC; k++) begin
            pat_byte[k] = pattern_reg[k*spwt_pkg::BYTE_W +: spwt_pkg::BYTE_W];
        end
        for (int k = 0; k < NC; k++) begin
            in_use[k] = spwt_pkg::LEN_W'(k) < eff_len;
            pos[k]    = eff_len - spwt_pkg::LEN_W'(1) - spwt_pkg::LEN_W'(k);
            want[k]   = pat_byte[pos[k][spwt_pkg::PAT_IDX_W-1:0]];
        end
    end

    // session state and idle timer
    logic                         session_reg;
    logic                         session_next;
    logic [spwt_pkg::LIMIT_W-1:0] idle_reg;
    logic [spwt_pkg::LIMIT_W-1:0] idle_next;
    logic [spwt_pkg::LIMIT_W-1:0] idle_inc;

    // result register
    logic m_valid_reg;
    logic m_valid_next;
    logic m_outcome_reg;
    logic m_outcome_next;

    logic                s_fire;
    logic                match;
    logic [NC-1:0]       hit;
    spwt_pkg::cell_ctl_t ctl;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign match   = &hit;
    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + spwt_pkg::LIMIT_W'(1);

    // item decode
    always_comb begin
        session_next   = session_reg;
        idle_next      = idle_reg;
        ctl.shift      = 1'b0;
        ctl.clear      = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_outcome_next = m_outcome_reg;
        if (s_fire) begin
            if (s_cmd == spwt_pkg::CMD_START) begin
                session_next = 1'b1;
                idle_next    = '0;
                ctl.clear    = 1'b1;
            end else if (session_reg) begin
                case (s_cmd)
                    spwt_pkg::CMD_BYTE: begin
                        idle_next = '0;
                        if (s_rx_byte != '0) begin
                            ctl.shift = 1'b1;
                            if (match) begin
                                session_next   = 1'b0;
                                m_valid_next   = 1'b1;
                                m_outcome_next = spwt_pkg::OUT_FOUND;
                            end
                        end
                        if (s_rx_byte < spwt_pkg::CTRL_LIMIT) begin
                            ctl.clear = 1'b1;
                        end
                    end
                    spwt_pkg::CMD_TICK: begin
                        idle_next = idle_inc;
                        if (idle_inc >= limit_reg) begin
                            session_next   = 1'b0;
                            m_valid_next   = 1'b1;
                            m_outcome_next = spwt_pkg::OUT_TIMEOUT;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_outcome_reg <= m_outcome_next;
        if (!aresetn) begin
            session_reg <= 1'b0;
            idle_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            session_reg <= session_next;
            idle_reg    <= idle_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_outcome = m_outcome_reg;

    // row of window cells, cell 0 holds the newest byte
    logic [spwt_pkg::BYTE_W-1:0] cell_data  [NC];
    logic [NC-1:0]               cell_valid;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic [spwt_pkg::BYTE_W-1:0] d_in;
        logic                        v_in;
        if (k == 0) begin : g_head
            assign d_in = s_rx_byte;
            assign v_in = 1'b1;
        end else begin : g_body
            assign d_in = cell_data[k-1];
            assign v_in = cell_valid[k-1];
        end
        spwt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .in_use   (in_use[k]),
            .want     (want[k]),
            .data_in  (d_in),
            .valid_in (v_in),
            .data_q   (cell_data[k]),
            .valid_q  (cell_valid[k]),
            .hit      (hit[k])
        );
    end

    // oldest stored cell that a full-length match relies on
    logic [spwt_pkg::PAT_IDX_W-1:0] oldest_idx;

    assign oldest_idx = spwt_pkg::PAT_IDX_W'(eff_len - spwt_pkg::LEN_W'(2));

    // window fill stays a run of valid cells from the newest end
    a_fill_contiguous: assert property (@(posedge aclk) disable iff (!aresetn)
        ((cell_valid + NC'(1)) & cell_valid) == '0)
        else $error("window valid bits not contiguous");

    // a start leaves an open session with an empty window and zero idle count
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_cmd == spwt_pkg::CMD_START)
        |=> (session_reg && cell_valid == '0 && idle_reg == '0))
        else $error("start did not reset the session");

    // a new result always closes the session
    a_result_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_cmd != spwt_pkg::CMD_START && m_valid_next && !(m_valid_reg && !m_ready))
        |=> !session_reg)
        else $error("result given while session stays open");

    // no item is taken while a result waits unclaimed
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !s_fire)
        else $error("item accepted over a pending result");

    // a found outcome needs at least one stored byte fewer than the pattern length, besides the incoming byte
    a_found_filled: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && session_reg && s_cmd == spwt_pkg::CMD_BYTE && s_rx_byte != '0 && match)
        |-> (eff_len == spwt_pkg::LEN_W'(1) || cell_valid[oldest_idx]))
        else $error("match reported on a short window");

endmodule

`default_nettype wire
